// ===== src/htok_pkg.sv =====
// Shared types and constants for the HTTP request tokenizer.
`default_nettype none
package htok_pkg;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [4:0] HDR_COUNT_MAX   = 5'd31;
	localparam logic [4:0] HDR_LIMIT_RESET = 5'd20;
	localparam logic [1:0] REQ_TOKENS      = 2'd3;

	typedef enum logic [2:0] {
		KIND_METHOD  = 3'd0,
		KIND_PATH    = 3'd1,
		KIND_VERSION = 3'd2,
		KIND_NAME    = 3'd3,
		KIND_VALUE   = 3'd4
	} field_kind_t;

	typedef enum logic [4:0] {
		PH_REQ   = 5'b00001,
		PH_NAME  = 5'b00010,
		PH_LEAD  = 5'b00100,
		PH_VALUE = 5'b01000,
		PH_DROP  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		field_kind_t field_kind;
		logic [4:0]  header_number;
		logic        token_start;
		logic        done_res;
		logic [4:0]  header_total;
	} res_t;

endpackage
`default_nettype wire

// ===== src/http_request_tokenizer_unit.sv =====
// HTTP request tokenizer: one raw byte in, at most one tagged token byte out.
//
// Input stream: s_tdata carries the raw request byte, s_tlast marks the last
// byte of the message. Output stream: one item per kept byte, tagged with its
// field (method, path, version, header name, header value) in m_tuser; the
// message-end byte always yields an item with m_tlast high and the final
// header count. CR bytes, blanks between tokens and dropped lines give none.
// Config: cfg_we/cfg_wdata write the header limit; write it only while idle.
//
// Path: input register, parse, output register. Throughput: one byte per
// clock while no result waits on a stalled output; the parse state updates
// in a single pass between the input register and the output register.
// Reset: clears the parse state and sets the header limit to 20.
// Stall: while m_tready is low a held result stays put; a byte that makes no
// result still drains, and the input register keeps accepting as long as the
// byte it holds can leave.
`default_nettype none
module http_request_tokenizer_unit import htok_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,    // header_limit
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
	input  wire logic        s_tlast,      // message_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] out_byte, [8] byte_valid, [13:9] header_number,
	// [14] token_start, [19:15] header_total, [23:20] zero
	output logic [23:0]      m_tdata,
	output logic             m_tlast,      // done_res
	output logic [2:0]       m_tuser       // field_kind
);

	logic [4:0] limit_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       valid_s2;
	res_t       res_s2;
	res_t       res;
	logic       has_res;
	logic       s2_ready;
	logic       s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= HDR_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign s2_ready = !valid_s2 || m_tready;
	assign s1_fire  = valid_s1 && (!has_res || s2_ready);
	assign s_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	htok_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_limit (limit_q),
		.item_fire    (s1_fire),
		.data_byte    (byte_s1),
		.message_end  (end_s1),
		.res          (res),
		.has_res      (has_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire && has_res) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_res) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.header_total, res_s2.token_start,
		res_s2.header_number, res_s2.byte_valid, res_s2.out_byte};
	assign m_tlast  = res_s2.done_res;
	assign m_tuser  = res_s2.field_kind;

	// An item without a kept byte exists only for the message end.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.byte_valid |-> res_s2.done_res)
		else $error("empty item without message end");

	// A held input byte is not overwritten before it is consumed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("input register overwritten");

	// Header bytes point at a counted line.
	a_hnum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.byte_valid && (res_s2.field_kind == KIND_NAME ||
		res_s2.field_kind == KIND_VALUE) |-> res_s2.header_number < res_s2.header_total)
		else $error("header number beyond count");

	// Dropped bytes carry no tags.
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.byte_valid |-> !res_s2.token_start &&
		res_s2.field_kind == KIND_METHOD && res_s2.out_byte == 8'd0)
		else $error("tags on empty item");

endmodule
`default_nettype wire

// ===== src/htok_parse.sv =====
// Parse state and per-byte classification of the request stream.
`default_nettype none
module htok_parse import htok_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [4:0] header_limit,
	input  wire logic       item_fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       message_end,
	output res_t            res,
	output logic            has_res
);

	phase_t     phase_q, phase_d;
	logic [1:0] req_idx_q, req_idx_d;
	logic [4:0] hdr_cnt_q, hdr_cnt_d;
	logic       in_tok_q, in_tok_d;
	logic       line_q, line_d;

	always_comb begin
		logic        blank;
		logic        keep;
		logic        start;
		logic        opened;
		field_kind_t kind;

		blank     = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
		keep      = 1'b0;
		start     = 1'b0;
		opened    = 1'b0;
		kind      = KIND_METHOD;
		phase_d   = phase_q;
		req_idx_d = req_idx_q;
		hdr_cnt_d = hdr_cnt_q;
		in_tok_d  = in_tok_q;
		line_d    = line_q;

		// Open the header line when needed; drop the line past the limit.
		if (line_q) begin
			opened = 1'b1;
		end else if (hdr_cnt_q >= header_limit || hdr_cnt_q >= HDR_COUNT_MAX) begin
			opened = 1'b0;
		end else begin
			opened = 1'b1;
		end

		if (data_byte == CHAR_CR) begin
			keep = 1'b0;
		end else if (data_byte == CHAR_LF) begin
			if (phase_q != PH_REQ || line_q) begin
				phase_d  = PH_NAME;
				in_tok_d = 1'b0;
				line_d   = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_REQ: begin
					if (blank) begin
						in_tok_d = 1'b0;
					end else begin
						line_d = 1'b1;
						if (!in_tok_q && req_idx_q >= REQ_TOKENS) begin
							phase_d = PH_DROP;
						end else begin
							if (!in_tok_q) begin
								req_idx_d = req_idx_q + 2'd1;
								in_tok_d  = 1'b1;
								start     = 1'b1;
							end
							keep = 1'b1;
							kind = field_kind_t'({1'b0, req_idx_d - 2'd1});
						end
					end
				end
				PH_NAME: begin
					if (data_byte == CHAR_COLON) begin
						phase_d  = PH_LEAD;
						in_tok_d = 1'b0;
					end else if (in_tok_q || !blank) begin
						if (opened) begin
							keep     = 1'b1;
							kind     = KIND_NAME;
							start    = !in_tok_q;
							in_tok_d = 1'b1;
						end else begin
							phase_d = PH_DROP;
						end
					end
				end
				PH_LEAD: begin
					if (!blank) begin
						if (opened) begin
							phase_d  = PH_VALUE;
							keep     = 1'b1;
							kind     = KIND_VALUE;
							start    = 1'b1;
							in_tok_d = 1'b1;
						end else begin
							phase_d = PH_DROP;
						end
					end
				end
				PH_VALUE: begin
					keep = 1'b1;
					kind = KIND_VALUE;
				end
				default: begin
					keep = 1'b0;
				end
			endcase
			if (keep && (kind == KIND_NAME || kind == KIND_VALUE) && !line_q) begin
				hdr_cnt_d = hdr_cnt_q + 5'd1;
				line_d    = 1'b1;
			end
		end

		has_res           = keep || message_end;
		res.out_byte      = keep ? data_byte : 8'd0;
		res.byte_valid    = keep;
		res.field_kind    = keep ? kind : KIND_METHOD;
		res.header_number = (keep && (kind == KIND_NAME || kind == KIND_VALUE)) ?
			hdr_cnt_d - 5'd1 : 5'd0;
		res.token_start   = keep && start;
		res.done_res      = message_end;
		res.header_total  = hdr_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_REQ;
			req_idx_q <= '0;
			hdr_cnt_q <= '0;
			in_tok_q  <= 1'b0;
			line_q    <= 1'b0;
		end else if (item_fire) begin
			if (message_end) begin
				phase_q   <= PH_REQ;
				req_idx_q <= '0;
				hdr_cnt_q <= '0;
				in_tok_q  <= 1'b0;
				line_q    <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				req_idx_q <= req_idx_d;
				hdr_cnt_q <= hdr_cnt_d;
				in_tok_q  <= in_tok_d;
				line_q    <= line_d;
			end
		end
	end

	// Header count only grows between message ends.
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && !message_end |=> hdr_cnt_q >= $past(hdr_cnt_q))
		else $error("header count went down");

	// Token in progress on the request line implies a token was started.
	a_req_tok: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_REQ && in_tok_q |-> req_idx_q != 2'd0)
		else $error("request token open without index");

	// A kept header byte always belongs to an opened line.
	a_hdr_open: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && res.byte_valid && (res.field_kind == KIND_NAME ||
		res.field_kind == KIND_VALUE) |-> res.header_total != 5'd0)
		else $error("header byte without counted line");

endmodule
`default_nettype wire

// ===== tb/http_request_tokenizer_unit_test.sv =====
// Testbench for the HTTP request tokenizer: directed, header-limit and random request streams.
`timescale 1ns / 100ps
module http_request_tokenizer_unit_test;
	import htok_pkg::*;

	localparam int PIPE_LATENCY = 2;
	localparam int IDLE_PCT     = 23;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	http_request_tokenizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state mirrored from the block
	phase_t     phase      = PH_REQ;
	logic [1:0] req_tokens = '0;
	logic [4:0] hdr_count  = '0;
	logic       in_token   = 1'b0;
	logic       line_open  = 1'b0;
	logic [4:0] hdr_limit  = HDR_LIMIT_RESET;

	res_t expected_tokens[$];
	res_t oldest_token;
	int   errors     = 0;
	int   bytes_sent = 0;
	bit   steady     = 1'b0;

	function automatic bit is_blank(input logic [7:0] b);
		return b == CHAR_SPACE || b == CHAR_TAB;
	endfunction

	// count the current header line if not yet done; drop it when over the limit
	function automatic bit open_line();
		if (line_open)
			return 1'b1;
		if (hdr_count >= hdr_limit || hdr_count >= HDR_COUNT_MAX) begin
			phase = PH_DROP;
			return 1'b0;
		end
		hdr_count++;
		line_open = 1'b1;
		return 1'b1;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic last);
		logic        keep;
		logic        start;
		field_kind_t kind;
		logic [4:0]  hnum;
		res_t        r;
		keep  = 1'b0;
		start = 1'b0;
		kind  = KIND_METHOD;
		hnum  = '0;
		if (b == CHAR_LF) begin
			if (phase != PH_REQ || line_open) begin
				phase     = PH_NAME;
				in_token  = 1'b0;
				line_open = 1'b0;
			end
		end else if (b != CHAR_CR) begin
			case (phase)
				PH_REQ: begin
					if (is_blank(b)) begin
						in_token = 1'b0;
					end else begin
						line_open = 1'b1;
						if (!in_token) begin
							if (req_tokens >= REQ_TOKENS) begin
								phase = PH_DROP;
							end else begin
								req_tokens++;
								in_token = 1'b1;
								start    = 1'b1;
							end
						end
						if (phase == PH_REQ) begin
							keep = 1'b1;
							kind = field_kind_t'({1'b0, req_tokens - 2'd1});
						end
					end
				end
				PH_NAME: begin
					if (b == CHAR_COLON) begin
						phase    = PH_LEAD;
						in_token = 1'b0;
					end else if (in_token || !is_blank(b)) begin
						if (open_line()) begin
							keep     = 1'b1;
							kind     = KIND_NAME;
							start    = !in_token;
							in_token = 1'b1;
						end
					end
				end
				PH_LEAD: begin
					if (!is_blank(b) && open_line()) begin
						phase    = PH_VALUE;
						keep     = 1'b1;
						kind     = KIND_VALUE;
						start    = 1'b1;
						in_token = 1'b1;
					end
				end
				PH_VALUE: begin
					keep = 1'b1;
					kind = KIND_VALUE;
				end
				default: ;
			endcase
			if (keep && kind >= KIND_NAME)
				hnum = hdr_count - 5'd1;
		end
		if (keep || last) begin
			r = '0;
			if (keep) begin
				r.out_byte      = b;
				r.byte_valid    = 1'b1;
				r.field_kind    = kind;
				r.header_number = hnum;
				r.token_start   = start;
			end
			r.done_res     = last;
			r.header_total = hdr_count;
			expected_tokens.push_back(r);
		end
		if (last) begin
			phase      = PH_REQ;
			req_tokens = '0;
			hdr_count  = '0;
			in_token   = 1'b0;
			line_open  = 1'b0;
		end
	endfunction

	task automatic send_item(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tokenize_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], last_at_end && i == s.len() - 1);
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_header_limit(input logic [4:0] v);
		pause_until_drained();
		// bytes that give no item may still be in the pipe
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		hdr_limit = v;
	endtask

	task automatic send_blanks(input int n);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
	endtask

	task automatic send_token(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(33, 126));
			if (b == CHAR_COLON)
				b = 8'h5F;
			send_item(b, 1'b0);
		end
	endtask

	task automatic send_eol();
		if ($urandom_range(9) < 7)
			send_item(CHAR_CR, 1'b0);
		send_item(CHAR_LF, 1'b0);
	endtask

	task automatic send_random_message();
		int n;
		int n_hdr;
		if ($urandom_range(9) == 0)
			send_text(" \r\n", 1'b0);
		n = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3;
		for (int i = 0; i < n; i++) begin
			if (i > 0 || $urandom_range(3) == 0)
				send_blanks($urandom_range(1, 2));
			send_token($urandom_range(1, 6));
		end
		send_eol();
		n_hdr = ($urandom_range(19) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 5);
		for (int i = 0; i < n_hdr; i++) begin
			if ($urandom_range(9) == 0) begin
				n = $urandom_range(1, 6);
				for (int j = 0; j < n; j++)
					send_item(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				if ($urandom_range(4) == 0)
					send_blanks($urandom_range(1, 2));
				if ($urandom_range(9) != 0)
					send_token($urandom_range(1, 5));
				if ($urandom_range(9) != 0) begin
					send_item(CHAR_COLON, 1'b0);
					send_blanks($urandom_range(0, 2));
					n = $urandom_range(0, 6);
					for (int j = 0; j < n; j++)
						send_item(8'($urandom_range(32, 126)), 1'b0);
				end
			end
			send_eol();
		end
		// close cleanly, or cut the message off on any byte
		if ($urandom_range(6) == 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_item(CHAR_CR, 1'b0);
			send_item(CHAR_LF, 1'b1);
		end
	endtask

	task automatic test_directed();
		send_text(" \t\r\n", 1'b0);
		send_text("G\t/ V X\r\n", 1'b0);
		send_text("N", 1'b0);
		send_item(8'hFF, 1'b0);
		send_text(" :\t a: b\n", 1'b0);
		send_text(":v\n", 1'b0);
		send_text("Q\n\n", 1'b0);
		send_item(8'h00, 1'b1);
		send_item(CHAR_SPACE, 1'b1);
	endtask

	task automatic test_header_limit();
		int n;
		for (int pass = 0; pass < 5; pass++) begin
			case (pass)
				1: set_header_limit(5'd0);
				2: set_header_limit(5'd1);
				3: set_header_limit(5'd31);
				4: set_header_limit(5'd5);
				default: ;
			endcase
			n = hdr_limit + 2;
			send_text("M P V\r\n", 1'b0);
			for (int i = 0; i < n; i++)
				send_text("k:v\r\n", 1'b0);
			send_item(CHAR_CR, 1'b1);
		end
		// lower the limit below the count in the middle of a message
		set_header_limit(5'd31);
		send_text("M P V\nk:v\nk:v\nk:v\n", 1'b0);
		pause_until_drained();
		set_header_limit(5'd1);
		send_text("late:x\n", 1'b0);
		send_item(8'h65, 1'b1);
	endtask

	task automatic test_random();
		int first;
		int msg;
		logic [4:0] lim;
		first = bytes_sent;
		msg   = 0;
		while (bytes_sent - first < 560) begin
			steady = (bytes_sent - first >= 250 && bytes_sent - first < 450);
			if ($urandom_range(5) == 0) begin
				case ($urandom_range(3))
					0: lim = 5'd0;
					1: lim = 5'd31;
					default: lim = 5'($urandom_range(0, 31));
				endcase
				set_header_limit(lim);
			end else if (msg == 2 || $urandom_range(7) == 0) begin
				pause_until_drained();
			end
			send_random_message();
			msg++;
		end
		steady = 1'b0;
	endtask

	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("result item with none expected: m_tdata %h", m_tdata);
				errors++;
			end else begin
				oldest_token = expected_tokens.pop_front();
				check_field("out_byte", 32'(oldest_token.out_byte), 32'(m_tdata[7:0]));
				check_field("byte_valid", 32'(oldest_token.byte_valid), 32'(m_tdata[8]));
				check_field("field_kind", 32'(oldest_token.field_kind), 32'(m_tuser));
				check_field("header_number", 32'(oldest_token.header_number),
					32'(m_tdata[13:9]));
				check_field("token_start", 32'(oldest_token.token_start),
					32'(m_tdata[14]));
				check_field("done_res", 32'(oldest_token.done_res), 32'(m_tlast));
				check_field("header_total", 32'(oldest_token.header_total),
					32'(m_tdata[19:15]));
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_header_limit();
		test_random();
		pause_until_drained();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/htok_pkg.sv
src/htok_parse.sv
src/http_request_tokenizer_unit.sv
tb/http_request_tokenizer_unit_test.sv
